>>> src/vector_length_clamp_macros.svh
// assertion helpers for the vector length clamp
`ifndef VECTOR_LENGTH_CLAMP_MACROS_SVH
`define VECTOR_LENGTH_CLAMP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define VLC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vector_length_clamp: implication check failed");

// invariant checked on every rising clock edge outside reset
`define VLC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("vector_length_clamp: invariant check failed");

`endif

>>> src/vlc_pkg.sv
package vlc_pkg;

  localparam int FIELD_W = 32;
  localparam int LIMIT_W = 31;

  typedef struct packed {
    logic signed [FIELD_W-1:0] vec_x;
    logic signed [FIELD_W-1:0] vec_y;
    logic signed [FIELD_W-1:0] vec_z;
    logic [LIMIT_W-1:0]        length_limit;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic                      was_clamped;
  } out_t;

endpackage

>>> src/vlc_front.sv
module vlc_front #(
  parameter int CW = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vlc_pkg::in_t      in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2*CW-1:0]   sum_o,
  output logic [2*CW-2:0]   prod_o [3],
  output logic [CW-1:0]     mag_o [3],
  output logic [2:0]        neg_o,
  output logic              zero_o,
  output logic              clamp_o
);

  logic [CW-1:0] raw [3];
  logic [CW-1:0] mag_d [3];

  logic          v1_q, v2_q, v3_q, v4_q;
  logic          r1, r2, r3, r4;

  logic [CW-1:0]   mag1_q [3];
  logic [2:0]      neg1_q;
  logic [CW-2:0]   lim1_q;
  logic            zero1_q;

  logic [2*CW-1:0] sq2_q [3];
  logic [2*CW-1:0] lsq2_q;
  logic [2*CW-2:0] prod2_q [3];
  logic [CW-1:0]   mag2_q [3];
  logic [2:0]      neg2_q;
  logic            zero2_q;

  logic [2*CW-1:0] sum3_q;
  logic [2*CW-1:0] lsq3_q;
  logic [2*CW-2:0] prod3_q [3];
  logic [CW-1:0]   mag3_q [3];
  logic [2:0]      neg3_q;
  logic            zero3_q;

  logic [2*CW-1:0] sum4_q;
  logic [2*CW-2:0] prod4_q [3];
  logic [CW-1:0]   mag4_q [3];
  logic [2:0]      neg4_q;
  logic            zero4_q;
  logic            clamp4_q;

  assign raw[0] = in_data_i.vec_x[CW-1:0];
  assign raw[1] = in_data_i.vec_y[CW-1:0];
  assign raw[2] = in_data_i.vec_z[CW-1:0];

  // two's complement magnitude, the most negative value maps to 2^(CW-1)
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      mag_d[l] = raw[l][CW-1] ? (~raw[l] + 1'b1) : raw[l];
    end
  end

  assign r4 = !v4_q || out_ready_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;
  assign in_ready_o = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= in_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && in_valid_i) begin
      for (int l = 0; l < 3; l++) begin
        mag1_q[l] <= mag_d[l];
        neg1_q[l] <= raw[l][CW-1];
      end
      lim1_q  <= in_data_i.length_limit[CW-2:0];
      zero1_q <= (in_data_i.length_limit[CW-2:0] == '0);
    end
    if (r2 && v1_q) begin
      for (int l = 0; l < 3; l++) begin
        sq2_q[l]   <= mag1_q[l] * mag1_q[l];
        prod2_q[l] <= mag1_q[l] * lim1_q;
        mag2_q[l]  <= mag1_q[l];
      end
      lsq2_q  <= lim1_q * lim1_q;
      neg2_q  <= neg1_q;
      zero2_q <= zero1_q;
    end
    if (r3 && v2_q) begin
      // cannot overflow: three squares of at most 2^(2CW-2)
      sum3_q  <= sq2_q[0] + sq2_q[1] + sq2_q[2];
      lsq3_q  <= lsq2_q;
      prod3_q <= prod2_q;
      mag3_q  <= mag2_q;
      neg3_q  <= neg2_q;
      zero3_q <= zero2_q;
    end
    if (r4 && v3_q) begin
      sum4_q   <= sum3_q;
      clamp4_q <= sum3_q > lsq3_q;
      prod4_q  <= prod3_q;
      mag4_q   <= mag3_q;
      neg4_q   <= neg3_q;
      zero4_q  <= zero3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign sum_o       = sum4_q;
  assign prod_o      = prod4_q;
  assign mag_o       = mag4_q;
  assign neg_o       = neg4_q;
  assign zero_o      = zero4_q;
  assign clamp_o     = clamp4_q;

endmodule

>>> src/vlc_isqrt.sv
module vlc_isqrt #(
  parameter int CW   = 32,
  parameter int SB_W = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2*CW-1:0] rad_i,
  input  logic [SB_W-1:0] sb_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CW-1:0]   root_o,
  output logic [SB_W-1:0] sb_o
);

  localparam int RW = CW + 3;

  logic [2*CW-1:0] rad  [CW+1];
  logic [RW-1:0]   rem  [CW+1];
  logic [CW-1:0]   root [CW+1];
  logic [SB_W-1:0] sb   [CW+1];
  logic [CW:0]     vld;
  logic [CW+1:1]   rdy;

  assign rad[0]  = rad_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign sb[0]   = sb_i;
  assign vld[0]  = in_valid_i;
  assign rdy[CW+1] = out_ready_i;

  // one root bit per stage, two radicand bits brought down each time
  for (genvar k = 0; k < CW; k++) begin : g_stage
    logic [RW-1:0] pull;
    logic [RW-1:0] trial;
    logic          take;

    assign pull  = {rem[k][RW-3:0], rad[k][2*CW-1 -: 2]};
    assign trial = {1'b0, root[k], 2'b01};
    assign take  = pull >= trial;
    assign rdy[k+1] = !vld[k+1] || rdy[k+2];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (rdy[k+1]) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k+1] && vld[k]) begin
        rad[k+1]  <= rad[k] << 2;
        rem[k+1]  <= take ? (pull - trial) : pull;
        root[k+1] <= {root[k][CW-2:0], take};
        sb[k+1]   <= sb[k];
      end
    end
  end

  assign in_ready_o  = rdy[1];
  assign out_valid_o = vld[CW];
  assign root_o      = root[CW];
  assign sb_o        = sb[CW];

endmodule

>>> src/vlc_div.sv
module vlc_div #(
  parameter int CW   = 32,
  parameter int SB_W = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [2*CW-2:0] num_i [3],
  input  logic [CW-1:0]   den_i,
  input  logic [SB_W-1:0] sb_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [CW-1:0]   quo_o [3],
  output logic [SB_W-1:0] sb_o
);

  logic [CW-1:0]   rm  [CW+1][3];
  logic [CW-1:0]   nlo [CW+1][3];
  logic [CW-1:0]   qt  [CW+1][3];
  logic [CW-1:0]   den [CW+1];
  logic [SB_W-1:0] sb  [CW+1];
  logic [CW:0]     vld;
  logic [CW+1:1]   rdy;

  // quotient fits in CW bits, so the top numerator bits start below den
  for (genvar l = 0; l < 3; l++) begin : g_init
    assign rm[0][l]  = CW'(num_i[l][2*CW-2:CW]);
    assign nlo[0][l] = num_i[l][CW-1:0];
    assign qt[0][l]  = '0;
  end
  assign den[0] = den_i;
  assign sb[0]  = sb_i;
  assign vld[0] = in_valid_i;
  assign rdy[CW+1] = out_ready_i;

  for (genvar k = 0; k < CW; k++) begin : g_stage
    assign rdy[k+1] = !vld[k+1] || rdy[k+2];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[k+1] <= 1'b0;
      end else if (rdy[k+1]) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k+1] && vld[k]) begin
        den[k+1] <= den[k];
        sb[k+1]  <= sb[k];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [CW:0]   t;
      logic [CW:0]   diff;
      logic          take;

      assign t    = {rm[k][l], nlo[k][l][CW-1]};
      assign diff = t - {1'b0, den[k]};
      assign take = t >= {1'b0, den[k]};

      always_ff @(posedge clk_i) begin
        if (rdy[k+1] && vld[k]) begin
          rm[k+1][l]  <= take ? diff[CW-1:0] : t[CW-1:0];
          nlo[k+1][l] <= nlo[k][l] << 1;
          qt[k+1][l]  <= {qt[k][l][CW-2:0], take};
        end
      end
    end
  end

  assign in_ready_o  = rdy[1];
  assign out_valid_o = vld[CW];
  assign quo_o       = qt[CW];
  assign sb_o        = sb[CW];

endmodule

>>> src/vector_length_clamp.sv
// Clamps a signed fixed-point 3D vector to a length limit (2D: give vec_z = 0).
// A zero limit yields the zero vector with was_clamped set; a vector whose
// squared length is within limit^2 passes unchanged; otherwise each component
// becomes trunc(c * limit / floor(sqrt(x^2 + y^2 + z^2))). Only the low
// COMP_WIDTH bits of each component and COMP_WIDTH-1 bits of the limit are
// used, and results are sign-extended to 32 bits. One transaction is taken
// every cycle unless every stage is full while the output is stalled. The
// square root resolves one root bit per stage and is followed by the
// divider, which resolves one quotient bit per stage for all three lanes.
// Bubbles in the pipeline close up while the output is stalled.
`include "vector_length_clamp_macros.svh"

module vector_length_clamp #(
  parameter int COMP_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  vlc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output vlc_pkg::out_t out_data_o
);

  localparam int CW      = COMP_WIDTH;
  localparam int SQ_SB_W = 3*(2*CW-1) + 3*CW + 5;
  localparam int DV_SB_W = 3*CW + 5;
  localparam int DEPTH   = 2*CW + 5;
  localparam int CNT_W   = $clog2(DEPTH + 1);

  logic            fr_valid, fr_ready;
  logic [2*CW-1:0] fr_sum;
  logic [2*CW-2:0] fr_prod [3];
  logic [CW-1:0]   fr_mag [3];
  logic [2:0]      fr_neg;
  logic            fr_zero, fr_clamp;

  logic               sq_valid, sq_ready;
  logic [CW-1:0]      sq_root;
  logic [SQ_SB_W-1:0] sq_sb_in, sq_sb_out;
  logic [2*CW-2:0]    sq_prod [3];
  logic [DV_SB_W-1:0] dv_sb_in, dv_sb_out;

  logic            dv_valid, dv_ready;
  logic [CW-1:0]   dv_quo [3];
  logic [CW-1:0]   dv_mag [3];
  logic [2:0]      dv_neg;
  logic            dv_zero, dv_clamp;

  logic [vlc_pkg::FIELD_W-1:0] res [3];
  vlc_pkg::out_t   out_d, out_q;
  logic            out_v_q;
  logic [CNT_W-1:0] cnt_q;

  vlc_front #(.CW(CW)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .sum_o       (fr_sum),
    .prod_o      (fr_prod),
    .mag_o       (fr_mag),
    .neg_o       (fr_neg),
    .zero_o      (fr_zero),
    .clamp_o     (fr_clamp)
  );

  assign sq_sb_in = {fr_prod[0], fr_prod[1], fr_prod[2],
                     fr_mag[0], fr_mag[1], fr_mag[2], fr_neg, fr_zero, fr_clamp};

  vlc_isqrt #(.CW(CW), .SB_W(SQ_SB_W)) u_isqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .rad_i       (fr_sum),
    .sb_i        (sq_sb_in),
    .out_valid_o (sq_valid),
    .out_ready_i (sq_ready),
    .root_o      (sq_root),
    .sb_o        (sq_sb_out)
  );

  assign {sq_prod[0], sq_prod[1], sq_prod[2], dv_sb_in} = sq_sb_out;

  vlc_div #(.CW(CW), .SB_W(DV_SB_W)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sq_valid),
    .in_ready_o  (sq_ready),
    .num_i       (sq_prod),
    .den_i       (sq_root),
    .sb_i        (dv_sb_in),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .quo_o       (dv_quo),
    .sb_o        (dv_sb_out)
  );

  assign {dv_mag[0], dv_mag[1], dv_mag[2], dv_neg, dv_zero, dv_clamp} = dv_sb_out;

  // restore sign and widen to the 32-bit result fields
  always_comb begin
    logic [vlc_pkg::FIELD_W-1:0] ext;
    for (int l = 0; l < 3; l++) begin
      ext = vlc_pkg::FIELD_W'(dv_clamp ? dv_quo[l] : dv_mag[l]);
      if (dv_zero) begin
        res[l] = '0;
      end else begin
        res[l] = dv_neg[l] ? (~ext + 1'b1) : ext;
      end
    end
    out_d.out_x       = res[0];
    out_d.out_y       = res[1];
    out_d.out_z       = res[2];
    out_d.was_clamped = dv_zero || dv_clamp;
  end

  assign dv_ready = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (dv_ready) begin
      out_v_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_ready && dv_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // transactions in flight, for checking only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case ({in_valid_i && in_ready_o, out_valid_o && out_ready_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `VLC_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(DEPTH))
  `VLC_ASSERT_IMP(a_out_has_item, out_valid_o, cnt_q != '0)
  `VLC_ASSERT_IMP(a_stall_from_out, !in_ready_o, out_valid_o && !out_ready_i)
  `VLC_ASSERT_IMP(a_full_blocks, cnt_q == CNT_W'(DEPTH), !in_ready_o || out_ready_i)

endmodule
